>>> hdl/svc_pkg.sv
// ----------------------------------------------------------------------------
// Short varint codec package
// Request and result types, job type and kind codes shared by the codec.
// ----------------------------------------------------------------------------
`default_nettype none

package svc_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	localparam logic ACTION_ENCODE = 1'b0;
	localparam logic ACTION_DECODE = 1'b1;

	typedef struct packed {
		logic        action;
		logic        is_signed;
		logic [31:0] value;
		logic [7:0]  in_byte;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [31:0] out_value;
		logic [2:0]  code_length;
		logic        last;
	} out_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] data;
		logic [2:0]  len;
	} job_t;

endpackage

`default_nettype wire

>>> hdl/short_varint_codec_unit.sv
// ----------------------------------------------------------------------------
// Short varint codec unit
// Encodes values into 1, 2 or 4 byte codes and decodes code bytes into values.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: a request is taken on a clock
// edge with push high and full low. Results leave the same way: the oldest
// result sits on the result port while empty is low and is taken on an edge
// with pop high. An encode request gives one result per code byte, or a single
// rejection; a decode request gives a value only on the byte that ends a code.
// A request can be taken every cycle while full is low. The front end
// classifies it in the cycle it is taken and writes a job into the job queue;
// the back end turns the oldest job into one result per cycle while the output
// register is empty or popped; a result passes through the job queue and the
// output register. Results drain at one per cycle while pop stays high, so a
// stream of multi-byte encodes runs at the rate set by their byte count.
// When pop stays low, the output register holds, the job queue fills and
// full rises; full falls again as soon as a job leaves the queue.
// Reset clears the decoder state, the job queue and the output register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module short_varint_codec_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire svc_pkg::in_t  item,
	output logic               empty,
	input  wire logic          pop,
	output svc_pkg::out_t      result
);

	logic          accept;
	logic          job_valid;
	svc_pkg::job_t job;
	svc_pkg::job_t head;
	logic          head_avail;
	logic          head_take;

	assign accept = push && !full;

	svc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.accept    (accept),
		.job_valid (job_valid),
		.job       (job)
	);

	svc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_data (job),
		.full    (full),
		.rd_en   (head_take),
		.rd_data (head),
		.nempty  (head_avail)
	);

	svc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head),
		.job_avail (head_avail),
		.job_take  (head_take),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

>>> hdl/svc_front.sv
// ----------------------------------------------------------------------------
// Short varint codec front end
// Classifies each request, sizes encodes and runs the byte-wise decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire svc_pkg::in_t  item,
	input  wire logic          accept,
	output logic               job_valid,
	output svc_pkg::job_t      job
);

	logic [1:0]  phase_q;
	logic [29:0] partial_q;
	logic        smode_q;
	logic        sign_q;

	logic [31:0] mag;
	logic        neg;
	logic [29:0] code;
	logic        enc_reject;
	logic [2:0]  enc_len;

	logic [1:0]  phase_d;
	logic [29:0] partial_d;
	logic        smode_d;
	logic        sign_d;
	logic        dec_done;
	logic [2:0]  dec_len;
	logic [31:0] dec_value;
	logic [7:0]  b;

	always_comb begin
		neg = item.is_signed & item.value[31];
		mag = neg ? (~item.value + 32'd1) : item.value;
		if (item.is_signed) begin
			enc_reject = (mag[31:29] != 3'd0);
			code       = {mag[28:0], neg};
			if (mag[31:6] == 26'd0) begin
				enc_len = 3'd1;
			end else if (mag[31:13] == 19'd0) begin
				enc_len = 3'd2;
			end else begin
				enc_len = 3'd4;
			end
		end else begin
			enc_reject = (item.value[31:30] != 2'd0);
			code       = item.value[29:0];
			if (item.value[31:7] == 25'd0) begin
				enc_len = 3'd1;
			end else if (item.value[31:14] == 18'd0) begin
				enc_len = 3'd2;
			end else begin
				enc_len = 3'd4;
			end
		end
	end

	always_comb begin
		b         = item.in_byte;
		phase_d   = phase_q;
		partial_d = partial_q;
		smode_d   = smode_q;
		sign_d    = sign_q;
		dec_done  = 1'b0;
		dec_len   = 3'd1;
		case (phase_q)
			2'd0: begin
				smode_d = item.is_signed;
				if (item.is_signed) begin
					sign_d    = b[0];
					partial_d = {24'd0, b[6:1]};
				end else begin
					sign_d    = 1'b0;
					partial_d = {23'd0, b[6:0]};
				end
				dec_done = !b[7];
				dec_len  = 3'd1;
				phase_d  = 2'd1;
			end
			2'd1: begin
				partial_d = partial_q |
					(smode_q ? ({23'd0, b[6:0]} << 6) : ({23'd0, b[6:0]} << 7));
				dec_done = !b[7];
				dec_len  = 3'd2;
				phase_d  = 2'd2;
			end
			2'd2: begin
				partial_d = partial_q |
					(smode_q ? ({22'd0, b} << 13) : ({22'd0, b} << 14));
				phase_d   = 2'd3;
			end
			2'd3: begin
				partial_d = partial_q |
					(smode_q ? ({22'd0, b} << 21) : ({22'd0, b} << 22));
				dec_done  = 1'b1;
				dec_len   = 3'd4;
			end
			default: begin
				phase_d = 2'd0;
			end
		endcase
		dec_value = (smode_d && sign_d) ? (~{2'd0, partial_d} + 32'd1) : {2'd0, partial_d};
	end

	always_comb begin
		job_valid = 1'b0;
		job.kind  = svc_pkg::KIND_BYTE;
		job.data  = 32'd0;
		job.len   = 3'd0;
		if (item.action == svc_pkg::ACTION_ENCODE) begin
			job_valid = accept;
			if (enc_reject) begin
				job.kind = svc_pkg::KIND_REJECT;
			end else begin
				job.data = {2'd0, code};
				job.len  = enc_len;
			end
		end else begin
			job_valid = accept && dec_done;
			job.kind  = svc_pkg::KIND_VALUE;
			job.data  = dec_value;
			job.len   = dec_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			partial_q <= 30'd0;
			smode_q   <= 1'b0;
			sign_q    <= 1'b0;
		end else if (accept && item.action == svc_pkg::ACTION_DECODE) begin
			smode_q <= smode_d;
			if (dec_done) begin
				phase_q   <= 2'd0;
				partial_q <= 30'd0;
				sign_q    <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				partial_q <= partial_d;
				sign_q    <= sign_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/svc_queue.sv
// ----------------------------------------------------------------------------
// Short varint codec job queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire svc_pkg::job_t  wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output svc_pkg::job_t       rd_data,
	output logic                nempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

	svc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == COUNT_MAX);
	assign nempty  = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= COUNT_MAX)
		else $error("Job queue count exceeds its depth.");

endmodule

`default_nettype wire

>>> hdl/svc_back.sv
// ----------------------------------------------------------------------------
// Short varint codec back end
// Expands queued jobs into output register records, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire svc_pkg::job_t  job,
	input  wire logic           job_avail,
	output logic                job_take,
	output svc_pkg::out_t       result,
	output logic                empty,
	input  wire logic           pop
);

	logic [1:0]    idx_q;
	logic          out_valid_q;
	svc_pkg::out_t out_q;
	logic [1:0]    last_idx;
	logic          load;
	logic          at_last;
	logic [29:0]   code;
	logic [7:0]    byte_sel;
	svc_pkg::out_t next_out;

	assign code     = job.data[29:0];
	assign last_idx = (job.kind == svc_pkg::KIND_BYTE) ? 2'(job.len - 3'd1) : 2'd0;
	assign at_last  = (idx_q == last_idx);
	assign load     = job_avail && (!out_valid_q || pop);
	assign job_take = load && at_last;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_comb begin
		case (idx_q)
			2'd0:    byte_sel = (job.len == 3'd1) ? {1'b0, code[6:0]} : {1'b1, code[6:0]};
			2'd1:    byte_sel = (job.len == 3'd2) ? {1'b0, code[13:7]} : {1'b1, code[13:7]};
			2'd2:    byte_sel = code[21:14];
			default: byte_sel = code[29:22];
		endcase
	end

	always_comb begin
		next_out.kind        = job.kind;
		next_out.out_byte    = 8'd0;
		next_out.out_value   = 32'd0;
		next_out.code_length = 3'd0;
		next_out.last        = 1'b1;
		case (job.kind)
			svc_pkg::KIND_BYTE: begin
				next_out.out_byte    = byte_sel;
				next_out.code_length = job.len;
				next_out.last        = at_last;
			end
			svc_pkg::KIND_VALUE: begin
				next_out.out_value   = job.data;
				next_out.code_length = job.len;
			end
			default: begin
				next_out.kind = svc_pkg::KIND_REJECT;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		job_avail |-> idx_q <= last_idx)
		else $error("Byte index ran past the end of the current code.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == svc_pkg::KIND_REJECT |->
		out_q.last && out_q.code_length == 3'd0)
		else $error("Rejection result is not a single final record.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$past(load) && $past(job.kind) == svc_pkg::KIND_BYTE |->
		out_q.last == ($past(idx_q) == $past(last_idx)))
		else $error("Last flag does not match the final byte of the code.");

endmodule

`default_nettype wire

>>> tb/tb_short_varint_codec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Short varint codec unit testbench
// Sends encode and decode requests through the queue-style input with bursty
// pacing, drains results under a changing stall pattern with one long hold,
// and checks every result field against a cycle-free model of the codec.
// ----------------------------------------------------------------------------

module tb_short_varint_codec_unit;

	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_ITEMS = 180;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_AT      = 80;
	localparam int HOLD_CYCLES  = 100;
	localparam int DRAIN_CYCLES = 10;

	class varint_codec_scoreboard;
		svc_pkg::out_t expected_results[$];
		logic [1:0]    dec_phase;
		logic [31:0]   dec_accum;
		logic          dec_signed;
		logic          dec_sign;
		int            errors;

		function new();
			dec_phase  = 2'd0;
			dec_accum  = '0;
			dec_signed = 1'b0;
			dec_sign   = 1'b0;
			errors     = 0;
		endfunction

		function void add_result(svc_pkg::kind_t kind, logic [7:0] code_byte,
			logic [31:0] val, logic [2:0] len, logic last);
			svc_pkg::out_t r;
			r.kind        = kind;
			r.out_byte    = code_byte;
			r.out_value   = val;
			r.code_length = len;
			r.last        = last;
			expected_results.push_back(r);
		endfunction

		function void emit_code(logic [31:0] code, int len);
			logic [7:0] code_bytes [4];
			code_bytes[0] = {len != 1, code[6:0]};
			code_bytes[1] = {len == 4, code[13:7]};
			code_bytes[2] = code[21:14];
			code_bytes[3] = code[29:22];
			for (int i = 0; i < len; i++)
				add_result(svc_pkg::KIND_BYTE, code_bytes[i], '0, 3'(len), i == len - 1);
		endfunction

		function void finish_decode(logic [2:0] len);
			logic [31:0] v;
			v = {2'b00, dec_accum[29:0]};
			if (dec_signed && dec_sign)
				v = -v;
			dec_phase = 2'd0;
			dec_accum = '0;
			dec_sign  = 1'b0;
			add_result(svc_pkg::KIND_VALUE, 8'h00, v, len, 1'b1);
		endfunction

		function void note_request(svc_pkg::in_t req);
			logic [31:0] mag;
			logic [31:0] code;
			logic [7:0]  b;
			b = req.in_byte;
			if (req.action == svc_pkg::ACTION_ENCODE) begin
				if (!req.is_signed) begin
					if (req.value >= 32'h4000_0000)
						add_result(svc_pkg::KIND_REJECT, 8'h00, '0, 3'd0, 1'b1);
					else if (req.value < 32'h80)
						emit_code(req.value, 1);
					else if (req.value < 32'h4000)
						emit_code(req.value, 2);
					else
						emit_code(req.value, 4);
				end else begin
					mag  = req.value[31] ? -req.value : req.value;
					code = {mag[30:0], req.value[31]};
					if (mag[31:29] != 3'b000)
						add_result(svc_pkg::KIND_REJECT, 8'h00, '0, 3'd0, 1'b1);
					else if (mag < 32'd64)
						emit_code(code, 1);
					else if (mag < 32'd8192)
						emit_code(code, 2);
					else
						emit_code(code, 4);
				end
			end else begin
				case (dec_phase)
					2'd0: begin
						dec_signed = req.is_signed;
						dec_sign   = req.is_signed & b[0];
						dec_accum  = req.is_signed ? {26'd0, b[6:1]} : {25'd0, b[6:0]};
						if (!b[7])
							finish_decode(3'd1);
						else
							dec_phase = 2'd1;
					end
					2'd1: begin
						dec_accum = (dec_accum | ({25'd0, b[6:0]} << (dec_signed ? 6 : 7)))
							& 32'h3fff_ffff;
						if (!b[7])
							finish_decode(3'd2);
						else
							dec_phase = 2'd2;
					end
					2'd2: begin
						dec_accum = (dec_accum | ({24'd0, b} << (dec_signed ? 13 : 14)))
							& 32'h3fff_ffff;
						dec_phase = 2'd3;
					end
					default: begin
						dec_accum = (dec_accum | ({24'd0, b} << (dec_signed ? 21 : 22)))
							& 32'h3fff_ffff;
						finish_decode(3'd4);
					end
				endcase
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(svc_pkg::out_t got);
			svc_pkg::out_t want;
			if (expected_results.size() == 0) begin
				$error("result with nothing pending: kind %0d, byte %0h, value %0h",
					got.kind, got.out_byte, got.out_value);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("out_byte", want.out_byte, got.out_byte);
			compare_field("out_value", want.out_value, got.out_value);
			compare_field("code_length", want.code_length, got.code_length);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          push;
	logic          full;
	svc_pkg::in_t  item;
	logic          empty;
	logic          pop;
	svc_pkg::out_t result;

	varint_codec_scoreboard sb;
	int burst_left;
	int n_sent;
	int n_results;
	int idle_cycles;

	short_varint_codec_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	task automatic send(logic action, logic sgn, logic [31:0] value, logic [7:0] code_byte);
		svc_pkg::in_t req;
		int gap;
		req.action    = action;
		req.is_signed = sgn;
		req.value     = value;
		req.in_byte   = code_byte;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		burst_left--;
		push <= 1'b1;
		item <= req;
		do @(posedge clk); while (full);
		sb.note_request(req);
		n_sent++;
	endtask

	task automatic send_encode(logic sgn, logic [31:0] value);
		send(svc_pkg::ACTION_ENCODE, sgn, value, 8'($urandom));
	endtask

	task automatic send_decode(logic sgn, logic [7:0] code_byte);
		send(svc_pkg::ACTION_DECODE, sgn, $urandom, code_byte);
	endtask

	task automatic send_random_encode();
		logic        sgn;
		logic [31:0] v;
		sgn = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 200);
			1: v = $urandom_range(0, 20000);
			2: v = (sgn ? 32'h2000_0000 : 32'h4000_0000) + $urandom_range(0, 6) - 3;
			3: v = $urandom_range(0, 32'h3fff_ffff);
			default: v = $urandom;
		endcase
		if (sgn && $urandom_range(0, 1))
			v = -v;
		send_encode(sgn, v);
	endtask

	task automatic send_random_code();
		int         len;
		logic       sgn;
		logic [7:0] b;
		len = ($urandom_range(0, 2) == 0) ? 1 : ($urandom_range(0, 1) ? 2 : 4);
		sgn = 1'($urandom_range(0, 1));
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 0)
				b[7] = len > 1;
			else if (i == 1)
				b[7] = len > 2;
			send_decode(i == 0 ? sgn : 1'($urandom), b);
			if (i < len - 1 && $urandom_range(0, 4) == 0)
				send_random_encode();
		end
	endtask

	initial begin
		sb         = new();
		burst_left = 0;
		n_sent     = 0;
		arst_n     = 1'b0;
		push       = 1'b0;
		item       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_encode(1'b0, 32'd0);
		send_encode(1'b0, 32'd127);
		send_encode(1'b0, 32'd128);
		send_encode(1'b0, 32'd16383);
		send_encode(1'b0, 32'd16384);
		send_encode(1'b0, 32'h3fff_ffff);
		send_encode(1'b0, 32'h4000_0000);
		send_encode(1'b0, 32'hffff_ffff);
		send_encode(1'b1, 32'd0);
		send_encode(1'b1, 32'd63);
		send_encode(1'b1, -32'd64);
		send_encode(1'b1, 32'd8191);
		send_encode(1'b1, -32'd8192);
		send_encode(1'b1, 32'h1fff_ffff);
		send_encode(1'b1, -32'h1fff_ffff);
		send_encode(1'b1, 32'h2000_0000);
		send_encode(1'b1, 32'h8000_0000);
		// Negative zero, then a two-byte code with an encode in the middle.
		send_decode(1'b1, 8'h01);
		send_decode(1'b0, 8'hff);
		send_encode(1'b0, 32'd300);
		send_decode(1'b1, 8'h7f);
		// The signed form is taken from the first byte only.
		send_decode(1'b1, 8'h81);
		send_decode(1'b0, 8'hff);
		send_decode(1'b0, 8'hff);
		send_decode(1'b0, 8'hff);

		while (n_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: send_random_code();
				5, 6, 7: send_random_encode();
				default: send_decode(1'($urandom), 8'($urandom));
			endcase
		end
		push <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("short_varint_codec_unit: match");
		else
			$display("short_varint_codec_unit: mismatch");
		$finish;
	end

	initial begin
		int  mode;
		bit  held;
		logic next_pop;
		pop       = 1'b0;
		n_results = 0;
		held      = 1'b0;
		mode      = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(result);
				n_results++;
			end
			if (!held && n_results >= HOLD_AT) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 15) == 0)
				mode = $urandom_range(0, 2);
			case (mode)
				0: next_pop = 1'b1;
				1: next_pop = 1'($urandom_range(0, 1));
				default: next_pop = ($urandom_range(0, 3) == 0);
			endcase
			pop <= next_pop;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("short_varint_codec_unit: mismatch");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end else
			idle_cycles <= 0;
	end

endmodule
